// ----- rtl/tanm_pkg.sv -----
// Shared types and constants for the tile average / nearest palette match block.
// Used by every module under rtl/; depends on nothing.
package tanm_pkg;

    // Sizing of the palette memory and the tile accumulators
    localparam int PALETTE_DEPTH   = 64;
    localparam int IDX_W           = $clog2(PALETTE_DEPTH);
    localparam int SEARCH_MAX      = (PALETTE_DEPTH < 64) ? PALETTE_DEPTH : 64;
    localparam int MAX_TILE_PIXELS = 4096;
    localparam int CNT_W           = $clog2(MAX_TILE_PIXELS + 1);
    localparam int CHAN_W          = 8;
    localparam int SUM_W           = $clog2(MAX_TILE_PIXELS * 255 + 1);
    localparam int STEP_W          = $clog2(CHAN_W);
    localparam int ENTRY_W         = 3 * CHAN_W;
    localparam int DIST_W          = 18;
    localparam int PCNT_W          = 7;

    // Input operation codes
    localparam logic OP_PALETTE = 1'b0;
    localparam logic OP_TARGET  = 1'b1;

    // Color mode codes
    localparam logic MODE_GRAY = 1'b0;
    localparam logic MODE_RGB  = 1'b1;

    // Configuration register indexes
    localparam logic REG_COLOR_MODE    = 1'b0;
    localparam logic REG_PALETTE_COUNT = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_LOAD,
        ST_DIV,
        ST_WRITE,
        ST_SEARCH,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // Tag that travels with each palette read into the search unit
    typedef struct packed {
        logic             valid;
        logic             first;
        logic [IDX_W-1:0] index;
    } srch_tag_t;

endpackage

// ----- rtl/tanm_palette_ram.sv -----
// Palette memory: one write port, one read port, registered read data.
// Depends on tanm_pkg for depth and entry width.
module tanm_palette_ram
(
    input  logic                           clk,
    input  logic                           we,
    input  logic [tanm_pkg::IDX_W-1:0]     waddr,
    input  logic [tanm_pkg::ENTRY_W-1:0]   wdata,
    input  logic                           re,
    input  logic [tanm_pkg::IDX_W-1:0]     raddr,
    output logic [tanm_pkg::ENTRY_W-1:0]   rdata
);

    logic [tanm_pkg::ENTRY_W-1:0] mem [tanm_pkg::PALETTE_DEPTH];

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read one entry into the registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/tanm_divider.sv -----
// Three-channel restoring divider, one quotient bit per cycle per channel.
// Quotients are known to fit in one channel width. Depends on tanm_pkg.
module tanm_divider
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [tanm_pkg::SUM_W-1:0]    sum_red,
    input  logic [tanm_pkg::SUM_W-1:0]    sum_green,
    input  logic [tanm_pkg::SUM_W-1:0]    sum_blue,
    input  logic [tanm_pkg::CNT_W-1:0]    divisor,
    output logic                          last_step,
    output logic [tanm_pkg::CHAN_W-1:0]   quo_red,
    output logic [tanm_pkg::CHAN_W-1:0]   quo_green,
    output logic [tanm_pkg::CHAN_W-1:0]   quo_blue
);

    logic                          active_reg;
    logic [tanm_pkg::STEP_W-1:0]   step_reg;
    logic [tanm_pkg::CNT_W-1:0]    divisor_reg;
    logic [tanm_pkg::SUM_W-1:0]    rem_reg [3];
    logic [tanm_pkg::CHAN_W-1:0]   quo_reg [3];
    logic [tanm_pkg::SUM_W-1:0]    load_val [3];
    logic [tanm_pkg::SUM_W:0]      dsh;

    assign load_val[0] = sum_red;
    assign load_val[1] = sum_green;
    assign load_val[2] = sum_blue;

    assign last_step = active_reg && (step_reg == '0);
    assign quo_red   = quo_reg[0];
    assign quo_green = quo_reg[1];
    assign quo_blue  = quo_reg[2];

    // Shifted divisor for the current quotient bit
    assign dsh = (tanm_pkg::SUM_W + 1)'(divisor_reg) << step_reg;

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            step_reg   <= '0;
        end
        else if (load)
        begin
            active_reg <= 1'b1;
            step_reg   <= tanm_pkg::STEP_W'(tanm_pkg::CHAN_W - 1);
        end
        else if (active_reg)
        begin
            active_reg <= (step_reg != '0);
            step_reg   <= step_reg - 1'b1;
        end
    end

    // Hold the divisor for the whole division
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            divisor_reg <= divisor;
        end
    end

    // One restoring step per channel
    for (genvar ch = 0; ch < 3; ch++)
    begin : g_chan
        logic [tanm_pkg::SUM_W:0] trial;
        logic                     fits;

        assign trial = {1'b0, rem_reg[ch]} - dsh;
        assign fits  = !trial[tanm_pkg::SUM_W];

        always_ff @(posedge clk)
        begin
            if (load)
            begin
                rem_reg[ch] <= load_val[ch];
                quo_reg[ch] <= '0;
            end
            else if (active_reg)
            begin
                if (fits)
                begin
                    rem_reg[ch] <= trial[tanm_pkg::SUM_W-1:0];
                end
                quo_reg[ch] <= {quo_reg[ch][tanm_pkg::CHAN_W-2:0], fits};
            end
        end
    end

endmodule

// ----- rtl/tanm_search.sv -----
// Nearest-entry search: distance of each palette entry read to the tile
// average, keeping the first minimum. Depends on tanm_pkg.
module tanm_search
(
    input  logic                            clk,
    input  logic                            color_mode,
    input  tanm_pkg::srch_tag_t             tag,
    input  logic [tanm_pkg::ENTRY_W-1:0]    entry,
    input  logic [tanm_pkg::CHAN_W-1:0]     avg_red,
    input  logic [tanm_pkg::CHAN_W-1:0]     avg_green,
    input  logic [tanm_pkg::CHAN_W-1:0]     avg_blue,
    output logic [tanm_pkg::IDX_W-1:0]      best_index,
    output logic [tanm_pkg::DIST_W-1:0]     best_distance
);

    localparam int CW = tanm_pkg::CHAN_W;

    logic [CW-1:0]                 dr;
    logic [CW-1:0]                 dg;
    logic [CW-1:0]                 db;
    logic [2*CW-1:0]               sq_r;
    logic [2*CW-1:0]               sq_g;
    logic [2*CW-1:0]               sq_b;
    logic [tanm_pkg::DIST_W-1:0]   distance;
    logic [tanm_pkg::IDX_W-1:0]    best_index_reg;
    logic [tanm_pkg::DIST_W-1:0]   best_distance_reg;

    function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    // Per-channel distance
    always_comb
    begin
        dr   = abs_diff(entry[3*CW-1:2*CW], avg_red);
        dg   = abs_diff(entry[2*CW-1:CW], avg_green);
        db   = abs_diff(entry[CW-1:0], avg_blue);
        sq_r = dr * dr;
        sq_g = dg * dg;
        sq_b = db * db;
        if (color_mode == tanm_pkg::MODE_RGB)
        begin
            distance = tanm_pkg::DIST_W'(sq_r) + tanm_pkg::DIST_W'(sq_g)
                     + tanm_pkg::DIST_W'(sq_b);
        end
        else
        begin
            distance = tanm_pkg::DIST_W'(dr);
        end
    end

    // Keep the first strict minimum
    always_ff @(posedge clk)
    begin
        if (tag.valid && (tag.first || (distance < best_distance_reg)))
        begin
            best_index_reg    <= tag.index;
            best_distance_reg <= distance;
        end
    end

    assign best_index    = best_index_reg;
    assign best_distance = best_distance_reg;

endmodule

// ----- rtl/tile_average_nearest_match_core.sv -----
// Top level of the tile average / nearest palette match block: pixel
// accumulators, sequencer, APB registers. Uses tanm_pkg, tanm_divider,
// tanm_palette_ram and tanm_search.
//
// Usage:
//   Pixels enter on start/busy: a transaction is taken at a clock edge with
//   start high and busy low. Pixels without last are summed in one cycle
//   each, back to back. A pixel with last closes an image (operation 0) or
//   a tile (operation 1) and raises busy while the average is formed.
//   Average: the restoring divider forms it one quotient bit at a time.
//   Palette image: a write state then stores the average in the palette RAM
//   at the closing pixel's slot and busy drops; no result is produced.
//   Target tile: the search reads one palette entry per cycle from the RAM
//   read port, over min(palette_count, 64) entries but at least one, then a
//   drain state; done pulses for one cycle with the result, and busy drops
//   in that same cycle.
//   The receiver cannot stall: a result is valid only in the done cycle.
//   Registers (APB, pready always high): 0x0 color_mode, 0x4 palette_count.
//   Reset clears the accumulators and sets color_mode 1 and palette_count
//   64; the palette RAM is not cleared and must be written before searched.
module tile_average_nearest_match_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Pixel channel
    input  logic                              start,
    output logic                              busy,
    input  logic                              operation,
    input  logic [tanm_pkg::IDX_W-1:0]        slot,
    input  logic [tanm_pkg::CHAN_W-1:0]       red,
    input  logic [tanm_pkg::CHAN_W-1:0]       green,
    input  logic [tanm_pkg::CHAN_W-1:0]       blue,
    input  logic                              last,
    // Result channel
    output logic                              done,
    output logic [tanm_pkg::IDX_W-1:0]        best_index,
    output logic [tanm_pkg::DIST_W-1:0]       best_distance,
    output logic [tanm_pkg::CHAN_W-1:0]       avg_red,
    output logic [tanm_pkg::CHAN_W-1:0]       avg_green,
    output logic [tanm_pkg::CHAN_W-1:0]       avg_blue,
    output logic                              tile_overflow,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int SW = tanm_pkg::SUM_W;
    localparam int CW = tanm_pkg::CHAN_W;

    tanm_pkg::state_t                state_reg;
    tanm_pkg::state_t                state_next;

    logic                            color_mode_reg;
    logic [tanm_pkg::PCNT_W-1:0]     palette_count_reg;

    logic [SW-1:0]                   red_sum_reg;
    logic [SW-1:0]                   red_sum_next;
    logic [SW-1:0]                   green_sum_reg;
    logic [SW-1:0]                   green_sum_next;
    logic [SW-1:0]                   blue_sum_reg;
    logic [SW-1:0]                   blue_sum_next;
    logic [tanm_pkg::CNT_W-1:0]      count_reg;
    logic [tanm_pkg::CNT_W-1:0]      count_next;
    logic                            ovf_seen_reg;
    logic                            ovf_seen_next;

    logic                            op_reg;
    logic [tanm_pkg::IDX_W-1:0]      slot_reg;
    logic                            tile_ovf_reg;
    logic [tanm_pkg::IDX_W-1:0]      addr_reg;
    logic [tanm_pkg::IDX_W-1:0]      addr_next;
    tanm_pkg::srch_tag_t             tag_reg;
    tanm_pkg::srch_tag_t             tag_next;

    logic                            accept;
    logic                            cfg_write;
    logic                            div_load;
    logic                            div_last;
    logic [tanm_pkg::CNT_W-1:0]      divisor;
    logic [CW-1:0]                   quo_red;
    logic [CW-1:0]                   quo_green;
    logic [CW-1:0]                   quo_blue;
    logic [CW-1:0]                   mean_green;
    logic [CW-1:0]                   mean_blue;
    logic [tanm_pkg::PCNT_W-1:0]     limit;
    logic [tanm_pkg::IDX_W-1:0]      last_addr;
    logic                            mem_we;
    logic                            mem_re;
    logic [tanm_pkg::ENTRY_W-1:0]    mem_rdata;

    assign accept    = start && !busy;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg    <= tanm_pkg::MODE_RGB;
            palette_count_reg <= tanm_pkg::PCNT_W'(64);
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                tanm_pkg::REG_COLOR_MODE:    color_mode_reg    <= pwdata[0];
                tanm_pkg::REG_PALETTE_COUNT: palette_count_reg <= pwdata[tanm_pkg::PCNT_W-1:0];
                default:                     color_mode_reg    <= color_mode_reg;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (paddr[2])
            tanm_pkg::REG_COLOR_MODE:    prdata = {31'b0, color_mode_reg};
            tanm_pkg::REG_PALETTE_COUNT: prdata = {{(32 - tanm_pkg::PCNT_W){1'b0}},
                                                   palette_count_reg};
            default:                     prdata = '0;
        endcase
    end

    // Accumulate pixels, saturate the count, clear once the sums are taken
    always_comb
    begin
        red_sum_next   = red_sum_reg;
        green_sum_next = green_sum_reg;
        blue_sum_next  = blue_sum_reg;
        count_next     = count_reg;
        ovf_seen_next  = ovf_seen_reg;
        if (state_reg == tanm_pkg::ST_LOAD)
        begin
            red_sum_next   = '0;
            green_sum_next = '0;
            blue_sum_next  = '0;
            count_next     = '0;
            ovf_seen_next  = 1'b0;
        end
        else if (accept)
        begin
            if (count_reg < tanm_pkg::CNT_W'(tanm_pkg::MAX_TILE_PIXELS))
            begin
                red_sum_next = red_sum_reg + SW'(red);
                if (color_mode_reg == tanm_pkg::MODE_RGB)
                begin
                    green_sum_next = green_sum_reg + SW'(green);
                    blue_sum_next  = blue_sum_reg + SW'(blue);
                end
                count_next = count_reg + 1'b1;
            end
            else
            begin
                ovf_seen_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_sum_reg   <= '0;
            green_sum_reg <= '0;
            blue_sum_reg  <= '0;
            count_reg     <= '0;
            ovf_seen_reg  <= 1'b0;
        end
        else
        begin
            red_sum_reg   <= red_sum_next;
            green_sum_reg <= green_sum_next;
            blue_sum_reg  <= blue_sum_next;
            count_reg     <= count_next;
            ovf_seen_reg  <= ovf_seen_next;
        end
    end

    // Capture the closing pixel's operation and slot, and the overflow flag
    always_ff @(posedge clk)
    begin
        if (accept && last)
        begin
            op_reg   <= operation;
            slot_reg <= slot;
        end
        if (state_reg == tanm_pkg::ST_LOAD)
        begin
            tile_ovf_reg <= ovf_seen_reg;
        end
    end

    // Search length: at least one entry, at most the searchable depth
    always_comb
    begin
        limit = (palette_count_reg == '0) ? tanm_pkg::PCNT_W'(1) : palette_count_reg;
        if (limit > tanm_pkg::PCNT_W'(tanm_pkg::SEARCH_MAX))
        begin
            limit = tanm_pkg::PCNT_W'(tanm_pkg::SEARCH_MAX);
        end
        last_addr = tanm_pkg::IDX_W'(limit - 1'b1);
    end

    assign divisor = (count_reg == '0) ? tanm_pkg::CNT_W'(1) : count_reg;

    // Sequencer: next state and control strobes
    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        tag_next   = '0;
        div_load   = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        done       = 1'b0;
        busy       = 1'b1;
        unique case (state_reg)
            tanm_pkg::ST_ACCUM:
            begin
                busy = 1'b0;
                if (accept && last)
                begin
                    state_next = tanm_pkg::ST_LOAD;
                end
            end
            tanm_pkg::ST_LOAD:
            begin
                div_load   = 1'b1;
                state_next = tanm_pkg::ST_DIV;
            end
            tanm_pkg::ST_DIV:
            begin
                if (div_last)
                begin
                    addr_next  = '0;
                    state_next = (op_reg == tanm_pkg::OP_TARGET) ? tanm_pkg::ST_SEARCH
                                                                 : tanm_pkg::ST_WRITE;
                end
            end
            tanm_pkg::ST_WRITE:
            begin
                mem_we     = 1'b1;
                state_next = tanm_pkg::ST_ACCUM;
            end
            tanm_pkg::ST_SEARCH:
            begin
                mem_re         = 1'b1;
                tag_next.valid = 1'b1;
                tag_next.first = (addr_reg == '0);
                tag_next.index = addr_reg;
                addr_next      = addr_reg + 1'b1;
                if (addr_reg == last_addr)
                begin
                    state_next = tanm_pkg::ST_DRAIN;
                end
            end
            tanm_pkg::ST_DRAIN:
            begin
                state_next = tanm_pkg::ST_EMIT;
            end
            tanm_pkg::ST_EMIT:
            begin
                done       = 1'b1;
                busy       = 1'b0;
                state_next = tanm_pkg::ST_ACCUM;
                if (accept && last)
                begin
                    state_next = tanm_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = tanm_pkg::ST_ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tanm_pkg::ST_ACCUM;
            addr_reg  <= '0;
            tag_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            tag_reg   <= tag_next;
        end
    end

    // Averages; green and blue read as zero in gray mode
    assign mean_green = (color_mode_reg == tanm_pkg::MODE_RGB) ? quo_green : '0;
    assign mean_blue  = (color_mode_reg == tanm_pkg::MODE_RGB) ? quo_blue  : '0;

    tanm_divider u_divider
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (div_load),
        .sum_red   (red_sum_reg),
        .sum_green (green_sum_reg),
        .sum_blue  (blue_sum_reg),
        .divisor   (divisor),
        .last_step (div_last),
        .quo_red   (quo_red),
        .quo_green (quo_green),
        .quo_blue  (quo_blue)
    );

    tanm_palette_ram u_palette
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (slot_reg),
        .wdata ({quo_red, mean_green, mean_blue}),
        .re    (mem_re),
        .raddr (addr_reg),
        .rdata (mem_rdata)
    );

    tanm_search u_search
    (
        .clk           (clk),
        .color_mode    (color_mode_reg),
        .tag           (tag_reg),
        .entry         (mem_rdata),
        .avg_red       (quo_red),
        .avg_green     (mean_green),
        .avg_blue      (mean_blue),
        .best_index    (best_index),
        .best_distance (best_distance)
    );

    // Result fields
    assign avg_red       = quo_red;
    assign avg_green     = mean_green;
    assign avg_blue      = mean_blue;
    assign tile_overflow = tile_ovf_reg;

endmodule

// ----- test/tb_tile_average_nearest_match_core.sv -----
// Self-checking testbench for tile_average_nearest_match_core: pixel stimulus,
// APB register setup and an in-bench tile average / nearest match predictor.
// Depends on rtl/tanm_pkg.sv and the block's RTL only.
`timescale 1ns / 1ps

module tb_tile_average_nearest_match_core;

    typedef struct packed {
        logic [tanm_pkg::IDX_W-1:0]  index;
        logic [tanm_pkg::DIST_W-1:0] distance;
        logic [tanm_pkg::CHAN_W-1:0] red;
        logic [tanm_pkg::CHAN_W-1:0] green;
        logic [tanm_pkg::CHAN_W-1:0] blue;
        logic                        overflow;
    } match_t;

    // Block ports
    logic                          clk;
    logic                          rst_n     = 1'b0;
    logic                          start     = 1'b0;
    logic                          busy;
    logic                          operation = tanm_pkg::OP_PALETTE;
    logic [tanm_pkg::IDX_W-1:0]    slot      = '0;
    logic [tanm_pkg::CHAN_W-1:0]   red       = '0;
    logic [tanm_pkg::CHAN_W-1:0]   green     = '0;
    logic [tanm_pkg::CHAN_W-1:0]   blue      = '0;
    logic                          last      = 1'b0;
    logic                          done;
    logic [tanm_pkg::IDX_W-1:0]    best_index;
    logic [tanm_pkg::DIST_W-1:0]   best_distance;
    logic [tanm_pkg::CHAN_W-1:0]   avg_red;
    logic [tanm_pkg::CHAN_W-1:0]   avg_green;
    logic [tanm_pkg::CHAN_W-1:0]   avg_blue;
    logic                          tile_overflow;
    logic                          psel      = 1'b0;
    logic                          penable   = 1'b0;
    logic                          pwrite    = 1'b0;
    logic [2:0]                    paddr     = '0;
    logic [31:0]                   pwdata    = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    // Predictor state: palette, accumulators and configuration
    logic [tanm_pkg::ENTRY_W-1:0]       palette_mem [tanm_pkg::PALETTE_DEPTH];
    logic [tanm_pkg::PALETTE_DEPTH-1:0] slot_written = '0;
    logic [tanm_pkg::SUM_W-1:0]         sum_r = '0;
    logic [tanm_pkg::SUM_W-1:0]         sum_g = '0;
    logic [tanm_pkg::SUM_W-1:0]         sum_b = '0;
    logic [tanm_pkg::CNT_W-1:0]         pix_count = '0;
    logic                               ovf_seen = 1'b0;
    logic                               cfg_mode = tanm_pkg::MODE_RGB;
    logic [tanm_pkg::PCNT_W-1:0]        cfg_count = 7'd64;

    match_t expected_matches[$];
    int     mismatches   = 0;
    int     random_items = 0;
    logic   gaps_enabled = 1'b1;

    tile_average_nearest_match_core DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop for a hung run
    initial
    begin
        #40_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic int unsigned chan_diff(input logic [tanm_pkg::CHAN_W-1:0] a,
                                              input logic [tanm_pkg::CHAN_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic int unsigned search_limit();
        int unsigned lim;
        lim = (cfg_count == 0) ? 1 : cfg_count;
        if (lim > tanm_pkg::SEARCH_MAX)
            lim = tanm_pkg::SEARCH_MAX;
        return lim;
    endfunction

    // A tile may close only when every searched slot holds a written average
    function automatic logic search_ready();
        for (int i = 0; i < search_limit(); i++)
            if (!slot_written[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // Accumulate one pixel; on last, store the average or predict the match
    task automatic predict_pixel(input logic op, input logic [tanm_pkg::IDX_W-1:0] s,
                                 input logic [tanm_pkg::CHAN_W-1:0] r,
                                 input logic [tanm_pkg::CHAN_W-1:0] g,
                                 input logic [tanm_pkg::CHAN_W-1:0] b, input logic lst);
        int unsigned n, lim, d, dr, dg, db, best_d, best_i;
        logic [tanm_pkg::CHAN_W-1:0] ar, ag, ab;
        match_t m;
        if (pix_count < tanm_pkg::MAX_TILE_PIXELS)
        begin
            sum_r += r;
            if (cfg_mode == tanm_pkg::MODE_RGB)
            begin
                sum_g += g;
                sum_b += b;
            end
            pix_count++;
        end
        else
            ovf_seen = 1'b1;
        if (!lst)
            return;
        n  = (pix_count == 0) ? 1 : pix_count;
        ar = tanm_pkg::CHAN_W'(sum_r / n);
        ag = (cfg_mode == tanm_pkg::MODE_RGB) ? tanm_pkg::CHAN_W'(sum_g / n) : '0;
        ab = (cfg_mode == tanm_pkg::MODE_RGB) ? tanm_pkg::CHAN_W'(sum_b / n) : '0;
        if (op == tanm_pkg::OP_PALETTE)
        begin
            if (s < tanm_pkg::PALETTE_DEPTH)
            begin
                palette_mem[s]  = {ar, ag, ab};
                slot_written[s] = 1'b1;
            end
        end
        else
        begin
            lim    = search_limit();
            best_i = 0;
            best_d = 32'hFFFF_FFFF;
            for (int i = 0; i < lim; i++)
            begin
                dr = chan_diff(palette_mem[i][3*tanm_pkg::CHAN_W-1:2*tanm_pkg::CHAN_W], ar);
                dg = chan_diff(palette_mem[i][2*tanm_pkg::CHAN_W-1:tanm_pkg::CHAN_W], ag);
                db = chan_diff(palette_mem[i][tanm_pkg::CHAN_W-1:0], ab);
                d  = (cfg_mode == tanm_pkg::MODE_RGB) ? dr * dr + dg * dg + db * db : dr;
                if (d < best_d)
                begin
                    best_d = d;
                    best_i = i;
                end
            end
            m.index    = tanm_pkg::IDX_W'(best_i);
            m.distance = tanm_pkg::DIST_W'(best_d);
            m.red      = ar;
            m.green    = ag;
            m.blue     = ab;
            m.overflow = ovf_seen;
            expected_matches = {expected_matches, m};
        end
        sum_r     = '0;
        sum_g     = '0;
        sum_b     = '0;
        pix_count = '0;
        ovf_seen  = 1'b0;
    endtask

    // Present one pixel and hold it until the block takes it
    task automatic send_pixel(input logic op, input logic [tanm_pkg::IDX_W-1:0] s,
                              input logic [tanm_pkg::CHAN_W-1:0] r,
                              input logic [tanm_pkg::CHAN_W-1:0] g,
                              input logic [tanm_pkg::CHAN_W-1:0] b, input logic lst);
        @(negedge clk);
        start     <= 1'b1;
        operation <= op;
        slot      <= s;
        red       <= r;
        green     <= g;
        blue      <= b;
        last      <= lst;
        do
            @(posedge clk);
        while (busy);
        predict_pixel(op, s, r, g, b, lst);
    endtask

    task automatic hold_off(input int cycles);
        repeat (cycles) @(negedge clk) start <= 1'b0;
    endtask

    // Drop start, wait for every pending match and for busy to clear, then pause
    task automatic settle();
        @(negedge clk) start <= 1'b0;
        while (expected_matches.size() != 0)
            @(posedge clk);
        do
            @(posedge clk);
        while (busy);
        repeat (16) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk) penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write a register while idle, then read it back
    task automatic set_register(input logic idx, input logic [31:0] value);
        logic [31:0] readback;
        logic [2:0]  addr;
        settle();
        addr = {idx, 2'b00};
        apb_access(1'b1, addr, value, readback);
        if (idx == tanm_pkg::REG_COLOR_MODE)
            cfg_mode = value[0];
        else
            cfg_count = value[tanm_pkg::PCNT_W-1:0];
        apb_access(1'b0, addr, '0, readback);
        if (idx == tanm_pkg::REG_COLOR_MODE)
        begin
            if (readback[0] !== cfg_mode)
                report_mismatch("color_mode readback", readback[0], cfg_mode);
        end
        else if (readback[tanm_pkg::PCNT_W-1:0] !== cfg_count)
            report_mismatch("palette_count readback", readback[tanm_pkg::PCNT_W-1:0],
                            cfg_count);
    endtask

    function automatic logic [tanm_pkg::CHAN_W-1:0] random_channel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return tanm_pkg::CHAN_W'($urandom);
        endcase
    endfunction

    // One image or tile of random length; pixel operations before last are mixed
    task automatic send_random_image();
        int   len;
        logic final_op;
        len      = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        final_op = 1'($urandom_range(0, 1));
        if (final_op == tanm_pkg::OP_TARGET && !search_ready())
            final_op = tanm_pkg::OP_PALETTE;
        for (int k = 0; k < len; k++)
        begin
            if (gaps_enabled && $urandom_range(0, 99) < 16)
                hold_off(1);
            send_pixel((k == len - 1) ? final_op : 1'($urandom_range(0, 1)),
                       tanm_pkg::IDX_W'($urandom), random_channel(), random_channel(),
                       random_channel(), k == len - 1);
            random_items++;
        end
    endtask

    // Compare each match against the oldest prediction
    always @(posedge clk)
    begin : result_check
        match_t want;
        if (rst_n && done)
        begin
            if (expected_matches.size() == 0)
                report_mismatch("unexpected result, best_index", best_index, 0);
            else
            begin
                want = expected_matches.pop_front();
                if (best_index !== want.index)
                    report_mismatch("best_index", best_index, want.index);
                if (best_distance !== want.distance)
                    report_mismatch("best_distance", best_distance, want.distance);
                if (avg_red !== want.red)
                    report_mismatch("avg_red", avg_red, want.red);
                if (avg_green !== want.green)
                    report_mismatch("avg_green", avg_green, want.green);
                if (avg_blue !== want.blue)
                    report_mismatch("avg_blue", avg_blue, want.blue);
                if (tile_overflow !== want.overflow)
                    report_mismatch("tile_overflow", tile_overflow, want.overflow);
            end
        end
    end

    task automatic test_register_access();
        set_register(tanm_pkg::REG_COLOR_MODE, tanm_pkg::MODE_RGB);
        set_register(tanm_pkg::REG_PALETTE_COUNT, 1);
    endtask

    // Black and white extremes, truncated averages, largest distance
    task automatic test_extremes();
        send_pixel(tanm_pkg::OP_PALETTE, 0, 8'd0, 8'd0, 8'd0, 1'b1);
        send_pixel(tanm_pkg::OP_TARGET, 63, 8'd255, 8'd255, 8'd255, 1'b1);
        send_pixel(tanm_pkg::OP_TARGET, 0, 8'd0, 8'd0, 8'd0, 1'b1);
        send_pixel(tanm_pkg::OP_PALETTE, 0, 8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(tanm_pkg::OP_PALETTE, 0, 8'd0, 8'd0, 8'd0, 1'b1);
        send_pixel(tanm_pkg::OP_TARGET, 0, 8'd255, 8'd0, 8'd128, 1'b0);
        send_pixel(tanm_pkg::OP_TARGET, 0, 8'd254, 8'd1, 8'd0, 1'b0);
        send_pixel(tanm_pkg::OP_TARGET, 0, 8'd0, 8'd255, 8'd255, 1'b1);
    endtask

    // First minimum wins on ties; the last pixel's operation decides
    task automatic test_ties_and_mixed();
        send_pixel(tanm_pkg::OP_PALETTE, 1, 8'd200, 8'd100, 8'd50, 1'b1);
        send_pixel(tanm_pkg::OP_PALETTE, 2, 8'd200, 8'd100, 8'd50, 1'b1);
        send_pixel(tanm_pkg::OP_PALETTE, 3, 8'd0, 8'd0, 8'd0, 1'b1);
        set_register(tanm_pkg::REG_PALETTE_COUNT, 4);
        send_pixel(tanm_pkg::OP_TARGET, 0, 8'd200, 8'd100, 8'd50, 1'b1);
        send_pixel(tanm_pkg::OP_TARGET, 0, 8'd1, 8'd1, 8'd1, 1'b1);
        send_pixel(tanm_pkg::OP_TARGET, 0, 8'd10, 8'd20, 8'd30, 1'b0);
        send_pixel(tanm_pkg::OP_PALETTE, 2, 8'd30, 8'd40, 8'd50, 1'b1);
        send_pixel(tanm_pkg::OP_PALETTE, 5, 8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(tanm_pkg::OP_TARGET, 5, 8'd40, 8'd60, 8'd80, 1'b1);
    endtask

    // Write every slot, the top slot pure white
    task automatic test_fill_palette();
        int len;
        for (int s = 0; s < tanm_pkg::PALETTE_DEPTH; s++)
        begin
            len = (s == tanm_pkg::PALETTE_DEPTH - 1) ? 1 : $urandom_range(1, 3);
            for (int k = 0; k < len; k++)
                if (s == tanm_pkg::PALETTE_DEPTH - 1)
                    send_pixel(tanm_pkg::OP_PALETTE, tanm_pkg::IDX_W'(s), '1, '1, '1, 1'b1);
                else
                    send_pixel(tanm_pkg::OP_PALETTE, tanm_pkg::IDX_W'(s), random_channel(),
                               random_channel(), random_channel(), k == len - 1);
        end
        set_register(tanm_pkg::REG_PALETTE_COUNT, 64);
        repeat (6)
            send_pixel(tanm_pkg::OP_TARGET, 0, random_channel(), random_channel(),
                       random_channel(), 1'b1);
    endtask

    // Gray mode: only red counts; also the search length extremes
    task automatic test_gray_mode();
        set_register(tanm_pkg::REG_COLOR_MODE, tanm_pkg::MODE_GRAY);
        for (int s = 0; s < 8; s++)
            send_pixel(tanm_pkg::OP_PALETTE, tanm_pkg::IDX_W'(s * 7), random_channel(),
                       random_channel(), random_channel(), 1'b1);
        send_pixel(tanm_pkg::OP_TARGET, 0, 8'd0, 8'd255, 8'd255, 1'b1);
        send_pixel(tanm_pkg::OP_TARGET, 0, 8'd255, 8'd0, 8'd0, 1'b1);
        send_pixel(tanm_pkg::OP_TARGET, 0, 8'd100, 8'd17, 8'd200, 1'b0);
        send_pixel(tanm_pkg::OP_TARGET, 0, 8'd101, 8'd99, 8'd3, 1'b1);
        set_register(tanm_pkg::REG_PALETTE_COUNT, 127);
        repeat (4)
            send_pixel(tanm_pkg::OP_TARGET, 0, random_channel(), random_channel(),
                       random_channel(), 1'b1);
        set_register(tanm_pkg::REG_PALETTE_COUNT, 0);
        repeat (3)
            send_pixel(tanm_pkg::OP_TARGET, 0, random_channel(), random_channel(),
                       random_channel(), 1'b1);
        set_register(tanm_pkg::REG_COLOR_MODE, tanm_pkg::MODE_RGB);
        set_register(tanm_pkg::REG_PALETTE_COUNT, 64);
    endtask

    // Pixel count saturation: a full tile of white, then black pixels past the
    // limit that must be neither summed nor counted; the next tile starts clean
    task automatic test_overflow();
        for (int k = 0; k < tanm_pkg::MAX_TILE_PIXELS + 2; k++)
            if (k < tanm_pkg::MAX_TILE_PIXELS)
                send_pixel(tanm_pkg::OP_TARGET, 0, '1, '1, '1, 1'b0);
            else
                send_pixel(tanm_pkg::OP_TARGET, 0, '0, '0, '0,
                           k == tanm_pkg::MAX_TILE_PIXELS + 1);
        send_pixel(tanm_pkg::OP_TARGET, 0, random_channel(), random_channel(),
                   random_channel(), 1'b1);
    endtask

    // Sender waits for every pending match before going on
    task automatic test_drain_pause();
        repeat (3)
        begin
            send_pixel(tanm_pkg::OP_TARGET, 0, random_channel(), random_channel(),
                       random_channel(), 0);
            send_pixel(tanm_pkg::OP_TARGET, 0, random_channel(), random_channel(),
                       random_channel(), 1);
        end
        settle();
        repeat (3)
            send_pixel(tanm_pkg::OP_TARGET, 0, random_channel(), random_channel(),
                       random_channel(), 1'b1);
    endtask

    // Random phases, each under its own register setting
    task automatic test_random();
        int           phase_end;
        logic [31:0]  count_value;
        for (int phase = 0; phase < 8; phase++)
        begin
            case ($urandom_range(0, 5))
                0:       count_value = 0;
                1:       count_value = 1;
                2:       count_value = 64;
                3:       count_value = 127;
                default: count_value = $urandom_range(1, 64);
            endcase
            set_register(tanm_pkg::REG_COLOR_MODE,
                         (phase < 2) ? tanm_pkg::MODE_RGB : 1'($urandom_range(0, 1)));
            set_register(tanm_pkg::REG_PALETTE_COUNT, (phase == 0) ? 64 : count_value);
            gaps_enabled = (phase != 1);
            phase_end    = random_items + 100;
            while (random_items < phase_end)
            begin
                send_random_image();
                if ($urandom_range(0, 99) < 3)
                    settle();
            end
        end
        gaps_enabled = 1'b1;
    endtask

    initial
    begin
        for (int i = 0; i < tanm_pkg::PALETTE_DEPTH; i++)
            palette_mem[i] = '0;
        repeat (12) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        test_register_access();
        test_extremes();
        test_ties_and_mixed();
        test_fill_palette();
        test_gray_mode();
        test_overflow();
        test_drain_pause();
        test_random();

        // Let the last search finish and watch for stray results
        settle();
        repeat (80) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/tanm_pkg.sv
rtl/tanm_palette_ram.sv
rtl/tanm_divider.sv
rtl/tanm_search.sv
rtl/tile_average_nearest_match_core.sv
test/tb_tile_average_nearest_match_core.sv
